FILE: rtl/multi_keyword_substring_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyword matcher
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEYWORD_SUBSTRING_MATCHER_TOP_MACROS_SVH
`define MULTI_KEYWORD_SUBSTRING_MATCHER_TOP_MACROS_SVH

// same-cycle implication
`define MKSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mksm assertion failed");

// next-cycle implication
`define MKSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mksm assertion failed");

`endif

FILE: rtl/mksm_pkg.sv
// ----------------------------------------------------------------------------
// mksm_pkg
// Shared constants and the ASCII case fold for the keyword matcher.
// ----------------------------------------------------------------------------
package mksm_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeywordA   = 3'd0,
    RegKeywordB   = 3'd1,
    RegKeywordC   = 3'd2,
    RegKeywordD   = 3'd3,
    RegAlwaysAct  = 3'd4,
    RegKeywordTrg = 3'd5
  } reg_idx_e;

  localparam logic [7:0] CharUpA = 8'h41;
  localparam logic [7:0] CharUpZ = 8'h5A;
  localparam logic [7:0] CaseOfs = 8'h20;

  // map A-Z to a-z, leave every other byte alone
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      r = c + CaseOfs;
    end
    return r;
  endfunction

endpackage

FILE: rtl/mksm_key_dec.sv
// ----------------------------------------------------------------------------
// mksm_key_dec
// Folds each keyword, finds its length and lines its bytes up by window age:
// the byte expected at age i is keyword byte (len-1-i).
// ----------------------------------------------------------------------------
module mksm_key_dec #(
  parameter int unsigned NUM_KEYWORDS = 4,
  parameter int unsigned KEY_BYTES    = 8
) (
  input  logic [8*KEY_BYTES-1:0] key_i  [NUM_KEYWORDS],
  output logic [7:0]             exp_o  [KEY_BYTES][NUM_KEYWORDS],
  output logic [KEY_BYTES-1:0]   care_o [NUM_KEYWORDS],
  output logic [NUM_KEYWORDS-1:0] used_o
);

  localparam int unsigned LenW = $clog2(KEY_BYTES + 1);

  logic [7:0]      kb [KEY_BYTES];
  logic [LenW-1:0] len;
  logic            done;

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      done = 1'b0;
      len  = '0;
      for (int j = 0; j < KEY_BYTES; j++) begin
        kb[j] = mksm_pkg::fold(key_i[k][8*j +: 8]);
        // keyword ends at its first zero byte
        if (!done && kb[j] != 8'h00) begin
          len = len + 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      used_o[k] = (len != '0);
      for (int i = 0; i < KEY_BYTES; i++) begin
        exp_o[i][k]  = 8'h00;
        care_o[k][i] = 1'b0;
        for (int l = 1; l <= KEY_BYTES; l++) begin
          if (len == LenW'(l) && i < l) begin
            exp_o[i][k]  = kb[l-1-i];
            care_o[k][i] = 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/mksm_cell.sv
// ----------------------------------------------------------------------------
// mksm_cell
// One window slot: compares the byte at its age against every keyword and
// hands that byte on to the next slot per accepted request, zero at text end.
// ----------------------------------------------------------------------------
module mksm_cell #(
  parameter int unsigned NUM_KEYWORDS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    clr_i,
  input  logic [7:0]              byte_i,
  input  logic [7:0]              exp_i [NUM_KEYWORDS],
  output logic [NUM_KEYWORDS-1:0] eq_o,
  output logic [7:0]              byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      eq_o[k] = (byte_i == exp_i[k]);
    end
  end

  always_comb begin
    byte_d = byte_q;
    if (adv_i) begin
      byte_d = clr_i ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/multi_keyword_substring_matcher_top.sv
// ----------------------------------------------------------------------------
// multi_keyword_substring_matcher_top
// Case-insensitive search for up to four keywords in a zero-terminated text.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle unless m_axis stalls; the window shifts
//   through KEY_BYTES slot cells comparing against all keywords in parallel.
// The match result is on m_axis in the cycle after the terminating zero is taken.
// Reset clears the keyword and flag registers, the window and the per-text
//   flags; the block takes requests in the first cycle after reset.
`include "multi_keyword_substring_matcher_top_macros.svh"

module multi_keyword_substring_matcher_top #(
  parameter int unsigned NUM_KEYWORDS = 4,
  parameter int unsigned KEY_BYTES    = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mksm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mksm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] text_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata   // [0] matched, [7:1] zero
);

  logic [8*KEY_BYTES-1:0] kw_q [NUM_KEYWORDS];
  logic                   always_q, trig_q;
  logic                   found_q, found_d;
  logic                   nonempty_q, nonempty_d;
  logic                   mvalid_q, mvalid_d;
  logic                   mdata_q, mdata_d;

  logic                    accept, text_end;
  logic [7:0]              win [KEY_BYTES];
  logic [7:0]              exp [KEY_BYTES][NUM_KEYWORDS];
  logic [KEY_BYTES-1:0]    care [NUM_KEYWORDS];
  logic [NUM_KEYWORDS-1:0] used;
  logic [NUM_KEYWORDS-1:0] eq [KEY_BYTES];
  logic [NUM_KEYWORDS-1:0] hit;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        kw_q[k] <= '0;
      end
      always_q <= 1'b0;
      trig_q   <= 1'b0;
    end else if (cfg_we_i) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        if (cfg_idx_i == mksm_pkg::CfgIdxW'(k)) begin
          kw_q[k] <= cfg_data_i[8*KEY_BYTES-1:0];
        end
      end
      if (cfg_idx_i == mksm_pkg::RegAlwaysAct) begin
        always_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == mksm_pkg::RegKeywordTrg) begin
        trig_q <= cfg_data_i[0];
      end
    end
  end

  mksm_key_dec #(
    .NUM_KEYWORDS(NUM_KEYWORDS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_key_dec (
    .key_i (kw_q),
    .exp_o (exp),
    .care_o(care),
    .used_o(used)
  );

  assign s_axis_tready = !mvalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign text_end      = (s_axis_tdata == 8'h00);
  assign win[0]        = mksm_pkg::fold(s_axis_tdata);

  for (genvar i = 0; i < KEY_BYTES; i++) begin : g_cell
    if (i < KEY_BYTES - 1) begin : g_mid
      mksm_cell #(.NUM_KEYWORDS(NUM_KEYWORDS)) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .adv_i (accept),
        .clr_i (text_end),
        .byte_i(win[i]),
        .exp_i (exp[i]),
        .eq_o  (eq[i]),
        .byte_o(win[i+1])
      );
    end else begin : g_last
      // oldest slot only compares; nothing older is needed
      mksm_cell #(.NUM_KEYWORDS(NUM_KEYWORDS)) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .adv_i (accept),
        .clr_i (text_end),
        .byte_i(win[i]),
        .exp_i (exp[i]),
        .eq_o  (eq[i]),
        .byte_o()
      );
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      hit[k] = used[k];
      for (int i = 0; i < KEY_BYTES; i++) begin
        hit[k] = hit[k] & (eq[i][k] | ~care[k][i]);
      end
    end
  end

  always_comb begin
    found_d    = found_q;
    nonempty_d = nonempty_q;
    mvalid_d   = mvalid_q && !m_axis_tready;
    mdata_d    = mdata_q;
    if (accept) begin
      if (text_end) begin
        mvalid_d   = 1'b1;
        mdata_d    = always_q || (trig_q && nonempty_q && found_q);
        found_d    = 1'b0;
        nonempty_d = 1'b0;
      end else begin
        found_d    = found_q || (|hit);
        nonempty_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      nonempty_q <= 1'b0;
      mvalid_q   <= 1'b0;
    end else begin
      found_q    <= found_d;
      nonempty_q <= nonempty_d;
      mvalid_q   <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {7'b0, mdata_q};

  `MKSM_ASSERT_NEXT(a_end_gives_result, accept && text_end, m_axis_tvalid)
  `MKSM_ASSERT_NEXT(a_end_clears_text, accept && text_end, !found_q && !nonempty_q)
  `MKSM_ASSERT_NEXT(a_byte_marks_text, accept && !text_end, nonempty_q)
  `MKSM_ASSERT_NOW(a_found_needs_text, found_q, nonempty_q)
  `MKSM_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule
